>>> src/slfgt_pkg.sv
// ============================================================================
// Speed limit from gap and turn: shared package
// Payload structs, register indexes, limit selection codes and the CORDIC
// angle table used by the core.
// ============================================================================
package slfgt_pkg;

  localparam int CORDIC_STEPS_DEF = 14;
  localparam int ATAN_LEN         = 20;
  localparam int ZW               = 25;  // CORDIC angle, 1/65536 degree, signed
  localparam int CW               = 26;  // CORDIC vector components, signed

  localparam logic [15:0] HALF_TURN  = 16'd46080;
  localparam logic [ZW-1:0] QUARTER_Z = ZW'(90 * 65536);

  typedef enum logic [2:0] {
    REG_SPEED_MAX     = 3'd0,
    REG_SPEED_MIN     = 3'd1,
    REG_GAP_FAR       = 3'd2,
    REG_GAP_NEAR      = 3'd3,
    REG_TURN_STRAIGHT = 3'd4,
    REG_TURN_SHARP    = 3'd5
  } reg_idx_t;

  localparam logic [15:0] RST_SPEED_MAX     = 16'd410;
  localparam logic [15:0] RST_SPEED_MIN     = 16'd205;
  localparam logic [15:0] RST_GAP_FAR       = 16'd1536;
  localparam logic [15:0] RST_GAP_NEAR      = 16'd512;
  localparam logic [15:0] RST_TURN_STRAIGHT = 16'd1280;
  localparam logic [15:0] RST_TURN_SHARP    = 16'd6400;

  // Which value a limit takes: the lower register, the upper one, or
  // an interpolation between them.
  typedef enum logic [1:0] {
    SEL_MIN = 2'd0,
    SEL_MAX = 2'd1,
    SEL_INT = 2'd2
  } sel_t;

  typedef struct packed {
    logic               obstacle_seen;
    logic [15:0]        obstacle_gap;
    logic               point_valid;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
  } in_t;

  typedef struct packed {
    logic [15:0] speed_limit;
    logic [15:0] gap_limit;
    logic [15:0] turn_limit;
  } out_t;

  typedef struct packed {
    sel_t gap_sel;
    sel_t turn_sel;
    logic neg;
  } ctx_t;

  // atan(2^-i) in 1/65536 degree.
  function automatic logic [ZW-1:0] atan_lut(input int i);
    logic [ZW-1:0] r;
    case (i)
      0:       r = ZW'(2949120);
      1:       r = ZW'(1740967);
      2:       r = ZW'(919879);
      3:       r = ZW'(466945);
      4:       r = ZW'(234379);
      5:       r = ZW'(117304);
      6:       r = ZW'(58666);
      7:       r = ZW'(29335);
      8:       r = ZW'(14668);
      9:       r = ZW'(7334);
      10:      r = ZW'(3667);
      11:      r = ZW'(1833);
      12:      r = ZW'(917);
      13:      r = ZW'(458);
      14:      r = ZW'(229);
      15:      r = ZW'(115);
      16:      r = ZW'(57);
      17:      r = ZW'(29);
      18:      r = ZW'(14);
      19:      r = ZW'(7);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> src/slfgt_cordic.sv
// ============================================================================
// Speed limit from gap and turn: bearing CORDIC
// Vectoring CORDIC on (|x|, |y|), one iteration per register stage, then a
// stage that clamps, rounds to 1/256 degree and mirrors for negative x.
// ============================================================================
module slfgt_cordic
  import slfgt_pkg::*;
#(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  in_t         in_item,
  output logic        out_valid,
  output in_t         out_item,
  output logic [15:0] out_angle
);

  logic [STEPS:0]           v_r;
  logic signed [CW-1:0]     cx_r [0:STEPS];
  logic signed [CW-1:0]     cy_r [0:STEPS];
  logic signed [ZW-1:0]     z_r  [0:STEPS];
  in_t                      it_r [0:STEPS];

  logic        fin_v_r;
  in_t         fin_it_r;
  logic [15:0] fin_ang_r;

  // Shift toward zero.
  function automatic logic signed [CW-1:0] shr_sym(input logic signed [CW-1:0] v,
                                                   input int s);
    logic signed [CW-1:0] m;
    m = -v;
    if (v >= 0) return v >>> s;
    return -(m >>> s);
  endfunction

  logic [16:0] ax, ay;
  assign ax = in_item.point_x[15] ? 17'(-$signed({in_item.point_x[15], in_item.point_x}))
                                  : {1'b0, in_item.point_x};
  assign ay = in_item.point_y[15] ? 17'(-$signed({in_item.point_y[15], in_item.point_y}))
                                  : {1'b0, in_item.point_y};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0] <= CW'({ax, 8'd0});
      cy_r[0] <= CW'({ay, 8'd0});
      z_r[0]  <= '0;
      it_r[0] <= in_item;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [CW-1:0] dx, dy;
    assign dx = shr_sym(cy_r[i], i);
    assign dy = shr_sym(cx_r[i], i);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        it_r[i+1] <= it_r[i];
        if (cy_r[i] > 0) begin
          cx_r[i+1] <= cx_r[i] + dx;
          cy_r[i+1] <= cy_r[i] - dy;
          z_r[i+1]  <= z_r[i] + $signed(atan_lut(i));
        end else if (cy_r[i] < 0) begin
          cx_r[i+1] <= cx_r[i] - dx;
          cy_r[i+1] <= cy_r[i] + dy;
          z_r[i+1]  <= z_r[i] - $signed(atan_lut(i));
        end else begin
          cx_r[i+1] <= cx_r[i];
          cy_r[i+1] <= cy_r[i];
          z_r[i+1]  <= z_r[i];
        end
      end
    end
  end

  // A zero residual never moves the angle, so a zero y keeps z at zero.
  logic [ZW-1:0] zc;
  logic [ZW-1:0] zr;
  logic [15:0]   ang;
  always_comb begin
    if (z_r[STEPS] < 0) begin
      zc = '0;
    end else if ($unsigned(z_r[STEPS]) > QUARTER_Z) begin
      zc = QUARTER_Z;
    end else begin
      zc = $unsigned(z_r[STEPS]);
    end
    zr  = zc + ZW'(128);
    ang = 16'(zr >> 8);
    if (it_r[STEPS].point_x[15]) begin
      ang = HALF_TURN - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (en) begin
      fin_v_r <= v_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_it_r  <= it_r[STEPS];
      fin_ang_r <= ang;
    end
  end

  assign out_valid = fin_v_r;
  assign out_item  = fin_it_r;
  assign out_angle = fin_ang_r;

endmodule

>>> src/slfgt_div.sv
// ============================================================================
// Speed limit from gap and turn: pipelined divider
// Restoring division of a 32-bit dividend by a 16-bit divisor, one quotient
// bit per stage. The dividend must be below divisor * 2^16.
// ============================================================================
module slfgt_div
  import slfgt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] num,
  input  logic [15:0] den,
  output logic        out_valid,
  output logic [15:0] quo
);

  localparam int QW = 16;

  logic [QW:0]   v_r;
  logic [15:0]   rem_r [0:QW];
  logic [15:0]   low_r [0:QW];
  logic [15:0]   den_r [0:QW];
  logic [QW-1:0] q_r   [0:QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num[31:16];
      low_r[0] <= num[15:0];
      den_r[0] <= den;
      q_r[0]   <= '0;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_bit
    logic [16:0] trial;
    logic        ge;
    assign trial = {rem_r[s], low_r[s][QW-1-s]};
    assign ge    = trial >= {1'b0, den_r[s]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (en) begin
        v_r[s+1] <= v_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= ge ? 16'(trial - {1'b0, den_r[s]}) : trial[15:0];
        low_r[s+1] <= low_r[s];
        den_r[s+1] <= den_r[s];
        q_r[s+1]   <= {q_r[s][QW-2:0], ge};
      end
    end
  end

  assign out_valid = v_r[QW];
  assign quo       = q_r[QW];

endmodule

>>> src/speed_limit_from_gap_and_turn_core.sv
// ============================================================================
// Speed limit from gap and turn: core
// Forms a speed limit from the obstacle gap and the bearing of the next path
// point, and returns the smaller of the two limits.
// ============================================================================
// The core takes one transfer per clock while in_stall is low and returns
// one result transfer per input transfer, in order. The pipeline holds
// CORDIC_STEPS + 2 stages for the bearing CORDIC, two stages that
// classify the gap and bearing and form the interpolation products, seventeen
// stages of the bit-per-stage dividers, and the output register. The whole
// pipeline advances together; it halts only while a finished result sits in
// the output register and the receiver stalls, and then in_stall is raised.
// Registers are written over the APB port at byte addresses 4*i and must only
// be changed while no transfer is in flight.
module speed_limit_from_gap_and_turn_core
  import slfgt_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  // Register port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DIV_LAT = 17;

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic [15:0] speed_max_r, speed_min_r, gap_far_r, gap_near_r;
  logic [15:0] turn_straight_r, turn_sharp_r;
  reg_idx_t    widx;

  assign widx   = reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_max_r     <= RST_SPEED_MAX;
      speed_min_r     <= RST_SPEED_MIN;
      gap_far_r       <= RST_GAP_FAR;
      gap_near_r      <= RST_GAP_NEAR;
      turn_straight_r <= RST_TURN_STRAIGHT;
      turn_sharp_r    <= RST_TURN_SHARP;
    end else if (psel && penable && pwrite) begin
      case (widx)
        REG_SPEED_MAX:     speed_max_r     <= pwdata[15:0];
        REG_SPEED_MIN:     speed_min_r     <= pwdata[15:0];
        REG_GAP_FAR:       gap_far_r       <= pwdata[15:0];
        REG_GAP_NEAR:      gap_near_r      <= pwdata[15:0];
        REG_TURN_STRAIGHT: turn_straight_r <= pwdata[15:0];
        REG_TURN_SHARP:    turn_sharp_r    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_SPEED_MAX:     prdata = {16'd0, speed_max_r};
      REG_SPEED_MIN:     prdata = {16'd0, speed_min_r};
      REG_GAP_FAR:       prdata = {16'd0, gap_far_r};
      REG_GAP_NEAR:      prdata = {16'd0, gap_near_r};
      REG_TURN_STRAIGHT: prdata = {16'd0, turn_straight_r};
      REG_TURN_SHARP:    prdata = {16'd0, turn_sharp_r};
      default:           prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Global advance. Everything moves unless the output register holds a
  // result that the receiver is stalling.
  // --------------------------------------------------------------------------
  logic en;
  logic out_valid_r;
  out_t out_data_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // --------------------------------------------------------------------------
  // Bearing of the path point.
  // --------------------------------------------------------------------------
  logic        cor_valid;
  in_t         cor_item;
  logic [15:0] cor_angle;

  slfgt_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_item  (in_data),
    .out_valid(cor_valid),
    .out_item (cor_item),
    .out_angle(cor_angle)
  );

  // --------------------------------------------------------------------------
  // Classification stage: choose the case of each limit and form the offset
  // into its range and the width of the range.
  // --------------------------------------------------------------------------
  logic        cls_v_r;
  sel_t        cls_gsel_r, cls_tsel_r;
  logic [15:0] cls_gdel_r, cls_gden_r, cls_tdel_r, cls_tden_r;
  sel_t        gsel_nxt, tsel_nxt;

  always_comb begin
    if (!cor_item.obstacle_seen) begin
      gsel_nxt = SEL_MAX;
    end else if (cor_item.obstacle_gap <= gap_near_r) begin
      gsel_nxt = SEL_MIN;
    end else if (cor_item.obstacle_gap < gap_far_r) begin
      gsel_nxt = SEL_INT;
    end else begin
      gsel_nxt = SEL_MAX;
    end

    if (!cor_item.point_valid) begin
      tsel_nxt = SEL_MAX;
    end else if (cor_angle >= turn_sharp_r) begin
      tsel_nxt = SEL_MIN;
    end else if (cor_angle > turn_straight_r) begin
      tsel_nxt = SEL_INT;
    end else begin
      tsel_nxt = SEL_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_v_r <= 1'b0;
    end else if (en) begin
      cls_v_r <= cor_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls_gsel_r <= gsel_nxt;
      cls_tsel_r <= tsel_nxt;
      cls_gdel_r <= cor_item.obstacle_gap - gap_near_r;
      cls_gden_r <= gap_far_r - gap_near_r;
      cls_tdel_r <= cor_angle - turn_straight_r;
      cls_tden_r <= turn_sharp_r - turn_straight_r;
    end
  end

  // --------------------------------------------------------------------------
  // Product stage: |span| times the offset. The sign of the span is applied
  // after the divide, which truncates the magnitude toward zero.
  // --------------------------------------------------------------------------
  logic        span_neg;
  logic [15:0] span_mag;
  assign span_neg = speed_min_r > speed_max_r;
  assign span_mag = span_neg ? (speed_min_r - speed_max_r) : (speed_max_r - speed_min_r);

  logic        mul_v_r;
  ctx_t        mul_ctx_r;
  logic [31:0] mul_gnum_r, mul_tnum_r;
  logic [15:0] mul_gden_r, mul_tden_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
    end else if (en) begin
      mul_v_r <= cls_v_r;
    end
  end

  // Cases without interpolation divide zero by one to keep the divider's
  // range condition.
  always_ff @(posedge clk) begin
    if (en) begin
      mul_ctx_r  <= '{gap_sel: cls_gsel_r, turn_sel: cls_tsel_r, neg: span_neg};
      mul_gnum_r <= (cls_gsel_r == SEL_INT) ? span_mag * cls_gdel_r : 32'd0;
      mul_gden_r <= (cls_gsel_r == SEL_INT) ? cls_gden_r : 16'd1;
      mul_tnum_r <= (cls_tsel_r == SEL_INT) ? span_mag * cls_tdel_r : 32'd0;
      mul_tden_r <= (cls_tsel_r == SEL_INT) ? cls_tden_r : 16'd1;
    end
  end

  // --------------------------------------------------------------------------
  // Dividers, one per limit, with the case codes delayed alongside.
  // --------------------------------------------------------------------------
  logic        gdiv_v, tdiv_v;
  logic [15:0] gquo, tquo;

  slfgt_div u_gap_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (mul_v_r),
    .num      (mul_gnum_r),
    .den      (mul_gden_r),
    .out_valid(gdiv_v),
    .quo      (gquo)
  );

  slfgt_div u_turn_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (mul_v_r),
    .num      (mul_tnum_r),
    .den      (mul_tden_r),
    .out_valid(tdiv_v),
    .quo      (tquo)
  );

  ctx_t ctx_r [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_r[0] <= mul_ctx_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        ctx_r[k] <= ctx_r[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: pick each limit and the smaller of the two.
  // --------------------------------------------------------------------------
  ctx_t        ctx_end;
  logic [15:0] gq_s, tq_s, glim, tlim;

  assign ctx_end = ctx_r[DIV_LAT-1];
  assign gq_s    = ctx_end.neg ? 16'(-gquo) : gquo;
  assign tq_s    = ctx_end.neg ? 16'(-tquo) : tquo;

  always_comb begin
    case (ctx_end.gap_sel)
      SEL_MIN: glim = speed_min_r;
      SEL_INT: glim = speed_min_r + gq_s;
      default: glim = speed_max_r;
    endcase
    case (ctx_end.turn_sel)
      SEL_MIN: tlim = speed_min_r;
      SEL_INT: tlim = speed_max_r - tq_s;
      default: tlim = speed_max_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= gdiv_v && tdiv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= '{speed_limit: (glim < tlim) ? glim : tlim,
                      gap_limit:   glim,
                      turn_limit:  tlim};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> src/slfgt_checker.sv
// ============================================================================
// Speed limit from gap and turn: port checker
// Concurrent checks on the core's ports, bound to the core module.
// ============================================================================
module slfgt_checker
  import slfgt_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result does not change.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  // The combined limit is the smaller of the two limits.
  a_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.speed_limit == out_data.gap_limit ||
                   out_data.speed_limit == out_data.turn_limit) &&
                  out_data.speed_limit <= out_data.gap_limit &&
                  out_data.speed_limit <= out_data.turn_limit)
    else $error("speed limit is not the minimum");

  // Input is held back exactly while a finished result is stalled.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output stall");

  // Nothing comes out in the cycle after reset.
  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result after reset");

endmodule

bind speed_limit_from_gap_and_turn_core slfgt_checker u_slfgt_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

>>> tb/tb_speed_limit_from_gap_and_turn_core.sv
`timescale 1ns / 1ps
// ============================================================================
// Speed limit from gap and turn: core testbench
// Drives obstacle gaps and path points through the core under random input
// gaps and output stalls. It predicts each speed limit with its own CORDIC
// bearing and interpolation model and compares every result field in order.
// It also walks through several register settings written over the APB port.
// ============================================================================
module tb_speed_limit_from_gap_and_turn_core;
  import slfgt_pkg::*;

  localparam int STEPS     = 14;
  localparam int LATENCY   = 36;
  localparam int IDLE_LIMIT = 20000;
  localparam int IN_W      = $bits(in_t);

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  speed_limit_from_gap_and_turn_core #(.CORDIC_STEPS(STEPS)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Our own copy of the limit registers.
  logic [15:0] lim_regs [6];

  in_t  pending_points [$];
  out_t expected_limits [$];

  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  hold_receiver;   // request for a long receiver hold-off
  int  hold_left;
  bit  sender_paused;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bearing of (x, y) in 1/256 degree, folded to 0..180 degrees.
  function automatic logic [15:0] path_bearing(input logic signed [15:0] x,
                                               input logic signed [15:0] y);
    longint ax, ay, cx, cy, z, dx, dy;
    logic [15:0] ang;
    ax = (x < 0) ? -longint'(x) : longint'(x);
    ay = (y < 0) ? -longint'(y) : longint'(y);
    cx = ax * 256;
    cy = ay * 256;
    z  = 0;
    for (int i = 0; i < STEPS && i < ATAN_LEN; i++) begin
      // Shifts round toward zero on both signs.
      dx = (cy >= 0) ? (cy >>> i) : -((-cy) >>> i);
      dy = (cx >= 0) ? (cx >>> i) : -((-cx) >>> i);
      if (cy > 0) begin
        cx += dx; cy -= dy; z += longint'(atan_lut(i));
      end else if (cy < 0) begin
        cx -= dx; cy += dy; z -= longint'(atan_lut(i));
      end
    end
    if (ay == 0) z = 0;
    if (z < 0) z = 0;
    if (z > 90 * 65536) z = 90 * 65536;
    ang = 16'((z + 128) >>> 8);
    if (x < 0) ang = HALF_TURN - ang;
    return ang;
  endfunction

  function automatic out_t predict_limits(input in_t p);
    out_t r;
    longint vmax, vmin, span, num, den, ang;
    vmax = lim_regs[REG_SPEED_MAX];
    vmin = lim_regs[REG_SPEED_MIN];
    span = vmax - vmin;
    r.gap_limit  = 16'(vmax);
    r.turn_limit = 16'(vmax);
    if (p.obstacle_seen) begin
      if (p.obstacle_gap <= lim_regs[REG_GAP_NEAR]) begin
        r.gap_limit = 16'(vmin);
      end else if (p.obstacle_gap < lim_regs[REG_GAP_FAR]) begin
        num = span * (longint'(p.obstacle_gap) - longint'(lim_regs[REG_GAP_NEAR]));
        den = longint'(lim_regs[REG_GAP_FAR]) - longint'(lim_regs[REG_GAP_NEAR]);
        r.gap_limit = 16'(vmin + num / den);
      end
    end
    if (p.point_valid) begin
      ang = path_bearing(p.point_x, p.point_y);
      if (ang >= lim_regs[REG_TURN_SHARP]) begin
        r.turn_limit = 16'(vmin);
      end else if (ang > lim_regs[REG_TURN_STRAIGHT]) begin
        num = span * (ang - longint'(lim_regs[REG_TURN_STRAIGHT]));
        den = longint'(lim_regs[REG_TURN_SHARP]) - longint'(lim_regs[REG_TURN_STRAIGHT]);
        r.turn_limit = 16'(vmax - num / den);
      end
    end
    r.speed_limit = (r.gap_limit < r.turn_limit) ? r.gap_limit : r.turn_limit;
    return r;
  endfunction

  // Appends one item to the pending input queue.
  function automatic void enqueue_point(input in_t p);
    pending_points = {pending_points, p};
  endfunction

  // Sender: bursts of random length separated by random gaps. A payload
  // stays put while stalled; the prediction is made at acceptance so the
  // register copy matches what the core saw.
  int burst_left;
  int gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_limits = {expected_limits, predict_limits(in_data)};
      end
      if (!in_valid || !in_stall) begin
        if (pending_points.size() > 0 && !sender_paused && gap_left == 0) begin
          in_data  <= pending_points.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end
      end
    end
  end

  // Receiver stall pattern: phases of no stall, random stall and heavy
  // stall, plus the long hold-off that lets the pipeline fill.
  int phase_left;
  int stall_mode;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      phase_left <= 0;
      stall_mode <= 0;
      hold_left  <= 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_receiver) begin
      out_stall <= 1'b1;
      hold_left <= 200;
    end else begin
      if (phase_left == 0) begin
        phase_left <= $urandom_range(10, 80);
        stall_mode <= $urandom_range(0, 2);
      end else begin
        phase_left <= phase_left - 1;
      end
      case (stall_mode)
        0: begin
          out_stall <= 1'b0;
        end
        1: begin
          out_stall <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_stall <= ($urandom_range(0, 3) != 0);
        end
      endcase
    end
  end

  // Result checker and idle watchdog.
  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_valid && !out_stall) begin
        if (expected_limits.size() == 0) begin
          $display("%0t: unexpected result transfer %h", $time, out_data);
          mismatches++;
        end else begin
          want = expected_limits.pop_front();
          if (out_data.speed_limit !== want.speed_limit) begin
            $display("%0t: speed_limit expected %0d actual %0d", $time,
                     want.speed_limit, out_data.speed_limit);
            mismatches++;
          end
          if (out_data.gap_limit !== want.gap_limit) begin
            $display("%0t: gap_limit expected %0d actual %0d", $time,
                     want.gap_limit, out_data.gap_limit);
            mismatches++;
          end
          if (out_data.turn_limit !== want.turn_limit) begin
            $display("%0t: turn_limit expected %0d actual %0d", $time,
                     want.turn_limit, out_data.turn_limit);
            mismatches++;
          end
        end
      end
      if (idle_cycles > IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Register write: setup cycle, access cycle, then the bus goes idle.
  task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(4 * int'(idx));
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    lim_regs[idx] = value;
  endtask

  task automatic wait_drained();
    while (pending_points.size() > 0 || in_valid || expected_limits.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_limits(input logic [15:0] vmax, input logic [15:0] vmin,
                            input logic [15:0] gfar, input logic [15:0] gnear,
                            input logic [15:0] tstr, input logic [15:0] tsharp);
    write_reg(REG_SPEED_MAX, vmax);
    write_reg(REG_SPEED_MIN, vmin);
    write_reg(REG_GAP_FAR, gfar);
    write_reg(REG_GAP_NEAR, gnear);
    write_reg(REG_TURN_STRAIGHT, tstr);
    write_reg(REG_TURN_SHARP, tsharp);
  endtask

  function automatic in_t make_point(input int seen, input logic [15:0] gap,
                                     input int pv, input logic [15:0] x,
                                     input logic [15:0] y);
    in_t p;
    p.obstacle_seen = (seen != 0);
    p.obstacle_gap  = gap;
    p.point_valid   = (pv != 0);
    p.point_x       = x;
    p.point_y       = y;
    return p;
  endfunction

  // Mostly gaps and bearings near the configured ranges, with some fully
  // random values so every bit of every field toggles.
  task automatic queue_random(input int count);
    in_t p;
    int  sel;
    for (int n = 0; n < count; n++) begin
      p = in_t'(IN_W'({$urandom, $urandom}));
      sel = $urandom_range(0, 3);
      if (sel != 0) begin
        p.obstacle_seen = ($urandom_range(0, 5) != 0);
        p.point_valid   = ($urandom_range(0, 5) != 0);
        p.obstacle_gap  = 16'(int'(lim_regs[REG_GAP_NEAR]) + $urandom_range(0, 2000) - 200);
        if (sel == 1) begin
          p.point_x = 16'(int'($urandom_range(0, 4000)) - 2000);
          p.point_y = 16'(int'($urandom_range(0, 4000)) - 2000);
        end
      end
      enqueue_point(p);
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    hold_receiver = 1'b0;
    sender_paused = 1'b0;
    lim_regs[REG_SPEED_MAX]     = RST_SPEED_MAX;
    lim_regs[REG_SPEED_MIN]     = RST_SPEED_MIN;
    lim_regs[REG_GAP_FAR]       = RST_GAP_FAR;
    lim_regs[REG_GAP_NEAR]      = RST_GAP_NEAR;
    lim_regs[REG_TURN_STRAIGHT] = RST_TURN_STRAIGHT;
    lim_regs[REG_TURN_SHARP]    = RST_TURN_SHARP;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset settings: no obstacle, no point, the
    // origin point, gaps at and around both ends, the four quadrants and
    // points on the axes, and the field extremes.
    enqueue_point(make_point(0, 16'd0, 0, 16'd0, 16'd0));
    enqueue_point(make_point(1, 16'd512, 1, 16'd0, 16'd0));
    enqueue_point(make_point(1, 16'd513, 1, 16'd1024, 16'd0));
    enqueue_point(make_point(1, 16'd1000, 1, 16'd1024, 16'd100));
    enqueue_point(make_point(1, 16'd1535, 1, 16'd1024, 16'hff00));
    enqueue_point(make_point(1, 16'd1536, 1, 16'hfc00, 16'd50));
    enqueue_point(make_point(1, 16'hffff, 1, 16'hfc00, 16'hffce));
    enqueue_point(make_point(1, 16'd0, 1, 16'd0, 16'd300));
    enqueue_point(make_point(1, 16'd0, 1, 16'hfff0, 16'd0));
    enqueue_point(make_point(0, 16'hffff, 1, 16'h7fff, 16'h8000));
    enqueue_point(make_point(1, 16'd800, 1, 16'h8000, 16'h7fff));
    enqueue_point(make_point(1, 16'd800, 1, 16'h8000, 16'h8000));
    enqueue_point(make_point(1, 16'd800, 0, 16'h7fff, 16'h7fff));
    enqueue_point(make_point(1, 16'd1200, 1, 16'd1000, 16'd1000));
    wait_drained();

    // Zero-width ranges and inverted speeds.
    set_limits(16'd100, 16'd900, 16'd512, 16'd512, 16'd3000, 16'd3000);
    enqueue_point(make_point(1, 16'd511, 1, 16'd1000, 16'd300));
    enqueue_point(make_point(1, 16'd512, 1, 16'd1000, 16'd5));
    enqueue_point(make_point(1, 16'd513, 1, 16'hfc18, 16'd0));
    queue_random(60);
    wait_drained();

    // Register extremes.
    set_limits(16'hffff, 16'd0, 16'hffff, 16'd0, 16'd0, 16'd46080);
    queue_random(80);
    wait_drained();

    set_limits(16'd0, 16'hffff, 16'd0, 16'hffff, 16'd46080, 16'd0);
    queue_random(40);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering. The request
    // stays up until the receiver has started counting the hold-off.
    set_limits(RST_SPEED_MAX, RST_SPEED_MIN, RST_GAP_FAR, RST_GAP_NEAR,
               RST_TURN_STRAIGHT, RST_TURN_SHARP);
    queue_random(100);
    hold_receiver = 1'b1;
    while (hold_left == 0) @(posedge clk);
    hold_receiver = 1'b0;

    // Sender pause until every expected result is back, then resume.
    while (pending_points.size() > 50) @(posedge clk);
    sender_paused = 1'b1;
    while (in_valid || expected_limits.size() > 0) @(posedge clk);
    sender_paused = 1'b0;
    wait_drained();

    set_limits(16'd30000, 16'd1000, 16'd20000, 16'd2000, 16'd500, 16'd30000);
    queue_random(150);
    wait_drained();

    if (mismatches == 0 && expected_limits.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> speed_limit_from_gap_and_turn_core.f
src/slfgt_pkg.sv
src/slfgt_cordic.sv
src/slfgt_div.sv
src/speed_limit_from_gap_and_turn_core.sv
src/slfgt_checker.sv
tb/tb_speed_limit_from_gap_and_turn_core.sv
